// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro names the clock and the active-low reset that gate the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define CPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define CPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Types and codes shared by the profile column count table modules.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// Operation codes carried in the command word.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Status codes returned in the result word.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	localparam int unsigned DK_W = 7;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

	// One input word.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  residue;
		logic [7:0]  structure_code;
		logic [15:0] amount;
		logic [5:0]  entry_index;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [1:0]      status;
		logic [15:0]     key_count;
		logic [7:0]      out_residue;
		logic [7:0]      out_structure;
		logic [DK_W-1:0] distinct_keys;
		logic [23:0]     running_total;
	} rsp_t;

	// One table entry: the key (residue high) and its count.
	typedef struct packed {
		logic [7:0]  residue;
		logic [7:0]  structure_code;
		logic [15:0] count;
	} entry_t;

	// Outputs of the shared compare and add unit.
	typedef struct packed {
		logic        key_lt;
		logic        key_eq;
		logic [15:0] count_sum;
		logic [23:0] total_sum;
	} alu_out_t;

endpackage

// File: rtl/cpt_mem.sv
// ----------------------------------------------------------------------------
// cpt_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpt_mem
	import cpt_pkg::*;
#(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AW      = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [ENTRIES];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/cpt_alu.sv
// ----------------------------------------------------------------------------
// cpt_alu
// Shared unit: compares a stored key with the command key and forms the
// saturating count and total sums.
// ----------------------------------------------------------------------------
module cpt_alu
	import cpt_pkg::*;
(
	input  entry_t      entry,
	input  logic [15:0] key,
	input  logic [15:0] amount,
	input  logic [23:0] total,
	output alu_out_t    res
);

	logic [15:0] entry_key;
	logic [16:0] cnt_wide;
	logic [24:0] tot_wide;

	// Key compare, residue first, both unsigned.
	assign entry_key  = {entry.residue, entry.structure_code};
	assign res.key_lt = entry_key < key;
	assign res.key_eq = entry_key == key;

	// Saturating sums.
	assign cnt_wide      = 17'(entry.count) + 17'(amount);
	assign tot_wide      = 25'(total) + 25'(amount);
	assign res.count_sum = cnt_wide[16] ? COUNT_MAX : cnt_wide[15:0];
	assign res.total_sum = tot_wide[24] ? TOTAL_MAX : tot_wide[23:0];

endmodule

// File: rtl/profile_column_count_table_core.sv
// ----------------------------------------------------------------------------
// profile_column_count_table_core
// Sorted table of (residue, structure code) keys with saturating counts.
// ----------------------------------------------------------------------------
// Usage: drive a command word on command and raise start while busy is low;
// the word is taken at that clock edge. Opcodes: clear, add an amount to a
// key (a new key is inserted in sorted order), look up a key, read an entry
// by sorted index. Each command gives one result word on result, shown for
// exactly one cycle with done high; the receiver cannot stall it.
// Steps: clear, and a read by index past the population, answer straight
// from idle; a read by index reads the store and then answers. Look up and
// add scan the n held entries in order, each read and then compared, up to
// the first key that is not below the command key; a full table refuses
// after the same scan. A new key then moves the entries above its slot up
// by one, each read and then written, and writes the slot.
// Busy stays high until the cycle in which done rises, and a new command may
// be taken in that cycle.
// Reset clears the entry population, the running total and the sequencer;
// the entry store itself is not cleared, as entries past the population are
// never read.
// ----------------------------------------------------------------------------
module profile_column_count_table_core
	import cpt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t command,
	output logic done,
	output rsp_t result
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned PW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned CW = (PW > 6) ? PW : 6;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SRCH = 8'b0000_0010,
		S_CMP  = 8'b0000_0100,
		S_EVAL = 8'b0000_1000,
		S_SHRD = 8'b0001_0000,
		S_SHWR = 8'b0010_0000,
		S_INS  = 8'b0100_0000,
		S_RDIX = 8'b1000_0000
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [PW-1:0] pop_q;
	logic [23:0] total_q;
	logic [PW-1:0] i_q;
	logic [PW-1:0] j_q;
	logic        match_q;
	logic        done_q;
	rsp_t        result_q;

	logic [15:0]   key_q;
	logic [CW-1:0] idx_ext;
	logic [CW-1:0] pop_ext;
	logic [PW-1:0] j_dec;
	logic [DK_W-1:0] pop_dk;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;
	alu_out_t      alu_res;

	assign key_q   = {cmd_q.residue, cmd_q.structure_code};
	assign idx_ext = CW'(command.entry_index);
	assign pop_ext = CW'(pop_q);
	assign j_dec   = j_q - 1'b1;
	assign pop_dk  = DK_W'(pop_q);

	cpt_mem #(
		.ENTRIES(TABLE_ENTRIES),
		.AW     (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	cpt_alu u_alu (
		.entry (mem_rdata),
		.key   (key_q),
		.amount(cmd_q.amount),
		.total (total_q),
		.res   (alu_res)
	);

	// Store port control, decoded from the sequencer state.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		case (state_q)
			S_IDLE: begin
				mem_re    = start && (command.opcode == OP_READ) && (idx_ext < pop_ext);
				mem_raddr = idx_ext[AW-1:0];
			end
			S_SRCH: begin
				mem_re    = i_q < pop_q;
				mem_raddr = i_q[AW-1:0];
			end
			S_SHRD: begin
				mem_re    = 1'b1;
				mem_raddr = j_dec[AW-1:0];
			end
			S_EVAL: begin
				mem_we    = (cmd_q.opcode == OP_ADD) && match_q;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = {cmd_q.residue, cmd_q.structure_code, alu_res.count_sum};
			end
			S_SHWR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = {cmd_q.residue, cmd_q.structure_code, cmd_q.amount};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Sequencer with population, total and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			pop_q    <= '0;
			total_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			match_q  <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						i_q   <= '0;
						case (command.opcode)
							OP_CLEAR: begin
								pop_q    <= '0;
								total_q  <= '0;
								done_q   <= 1'b1;
								result_q <= '{ST_OK, 16'd0, 8'd0, 8'd0, '0, 24'd0};
							end
							OP_READ: begin
								if (idx_ext < pop_ext) begin
									state_q <= S_RDIX;
								end else begin
									done_q   <= 1'b1;
									result_q <= '{ST_BAD_INDEX, 16'd0, 8'd0, 8'd0,
										pop_dk, total_q};
								end
							end
							default: begin
								state_q <= S_SRCH;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (i_q < pop_q) begin
						state_q <= S_CMP;
					end else begin
						match_q <= 1'b0;
						state_q <= S_EVAL;
					end
				end
				S_CMP: begin
					if (alu_res.key_lt) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SRCH;
					end else begin
						match_q <= alu_res.key_eq;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cmd_q.opcode != OP_ADD) begin
						// Look up.
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						result_q <= '{match_q ? ST_OK : ST_NOT_FOUND,
							match_q ? mem_rdata.count : 16'd0,
							cmd_q.residue, cmd_q.structure_code, pop_dk, total_q};
					end else if (match_q) begin
						// Existing key gains the amount.
						total_q  <= alu_res.total_sum;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						result_q <= '{ST_OK, alu_res.count_sum, cmd_q.residue,
							cmd_q.structure_code, pop_dk, alu_res.total_sum};
					end else if (pop_q == PW'(TABLE_ENTRIES)) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						result_q <= '{ST_FULL, 16'd0, cmd_q.residue,
							cmd_q.structure_code, pop_dk, total_q};
					end else begin
						j_q     <= pop_q;
						state_q <= (pop_q > i_q) ? S_SHRD : S_INS;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					// Entry j-1 moved up to j; walk down to the slot.
					j_q     <= j_dec;
					state_q <= (j_dec > i_q) ? S_SHRD : S_INS;
				end
				S_INS: begin
					pop_q    <= pop_q + 1'b1;
					total_q  <= alu_res.total_sum;
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= '{ST_OK, cmd_q.amount, cmd_q.residue,
						cmd_q.structure_code, DK_W'(pop_q + 1'b1), alu_res.total_sum};
				end
				S_RDIX: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					result_q <= '{ST_OK, mem_rdata.count, mem_rdata.residue,
						mem_rdata.structure_code, pop_dk, total_q};
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the command and result handshake of the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_checker
	import cpt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t command,
	input logic done,
	input rsp_t result
);

	// A result word never shows while a command is still being worked on.
	`CPT_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !busy, "done while busy")

	// An accepted word either finishes at once or keeps the core busy.
	`CPT_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done, "accepted word lost")

	// The core only becomes busy after a word was offered.
	`CPT_ASSERT_NOW(a_busy_cause, clk, arst_n, $rose(busy), $past(start), "busy without start")

	// A full table reports no count.
	`CPT_ASSERT_NOW(a_full_zero, clk, arst_n, done && (result.status == ST_FULL), result.key_count == 16'd0, "count on full")

endmodule

bind profile_column_count_table_core cpt_checker u_cpt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.command(command),
	.done   (done),
	.result (result)
);

// File: test/tb_profile_column_count_table_core.sv
// ----------------------------------------------------------------------------
// tb_profile_column_count_table_core
// Self-checking bench for the sorted key count table core.
// ----------------------------------------------------------------------------
// A clocked driver feeds command words from a backlog that the stimulus block
// fills up front, with random gaps between words. Each accepted word runs
// through a local copy of the table, so the expected result word is known.
// A clocked monitor compares every result word, field by field, against the
// oldest expected word. The stimulus starts with a short directed sequence
// and continues with mixed traffic, full-table fills and a stretch that
// drives the counts and the running total into saturation.
// ----------------------------------------------------------------------------
module tb_profile_column_count_table_core;
	import cpt_pkg::*;

	localparam int unsigned TABLE_ENTRIES = 64;
	localparam int unsigned WORD_TARGET = 950;
	localparam int unsigned TAIL_CYCLES = 4 * TABLE_ENTRIES + 16;
	localparam int unsigned CYCLE_LIMIT = 1200000;
	localparam logic [15:0] CORNER_KEYS [4] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};

	// A queued command word; drain holds it back until all results are in.
	typedef struct {
		cmd_t word;
		bit   drain;
	} queued_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t command = '0;
	logic done;
	rsp_t result;

	queued_word_t command_backlog[$];
	rsp_t expected_results[$];
	bit drain_next;
	int unsigned total_words;
	int unsigned words_sent;
	int unsigned words_seen;
	int unsigned mismatches;
	int unsigned cycles_run;

	// Local copy of the table: keys and counts in sorted order.
	logic [15:0] column_keys [TABLE_ENTRIES];
	logic [15:0] column_counts [TABLE_ENTRIES];
	int unsigned keys_held;
	logic [23:0] column_total;

	// Coverage tallies for the closing summary.
	int unsigned op_tally [4];
	int unsigned adds_refused;
	int unsigned counts_capped;
	bit total_capped;

	// Driver state.
	bit offer;
	cmd_t next_word;
	queued_word_t head;
	int unsigned gap_left;
	bit steady;

	// Monitor state.
	rsp_t want;

	profile_column_count_table_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
	end

	// Apply one command word to the local table and return its result word.
	function automatic rsp_t column_response(cmd_t c);
		rsp_t r;
		logic [15:0] k;
		int unsigned pos;
		int unsigned j;
		logic [16:0] csum;
		logic [24:0] tsum;
		r = '0;
		k = {c.residue, c.structure_code};
		op_tally[c.opcode]++;
		pos = 0;
		while (pos < keys_held && column_keys[pos] < k) begin
			pos++;
		end
		case (c.opcode)
			OP_CLEAR: begin
				keys_held = 0;
				column_total = '0;
			end
			OP_ADD: begin
				r.out_residue = c.residue;
				r.out_structure = c.structure_code;
				if (pos < keys_held && column_keys[pos] == k) begin
					csum = 17'(column_counts[pos]) + 17'(c.amount);
					if (csum[16]) begin
						counts_capped++;
					end
					column_counts[pos] = csum[16] ? COUNT_MAX : csum[15:0];
					r.key_count = column_counts[pos];
				end else if (keys_held >= TABLE_ENTRIES) begin
					r.status = ST_FULL;
					adds_refused++;
				end else begin
					// New key: open a slot by moving the later entries up.
					for (j = keys_held; j > pos; j--) begin
						column_keys[j] = column_keys[j - 1];
						column_counts[j] = column_counts[j - 1];
					end
					column_keys[pos] = k;
					column_counts[pos] = c.amount;
					keys_held++;
					r.key_count = c.amount;
				end
				if (r.status != ST_FULL) begin
					tsum = 25'(column_total) + 25'(c.amount);
					if (tsum[24]) begin
						total_capped = 1'b1;
					end
					column_total = tsum[24] ? TOTAL_MAX : tsum[23:0];
				end
			end
			OP_LOOKUP: begin
				r.out_residue = c.residue;
				r.out_structure = c.structure_code;
				if (pos < keys_held && column_keys[pos] == k) begin
					r.key_count = column_counts[pos];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			default: begin
				if (c.entry_index < keys_held) begin
					r.key_count = column_counts[c.entry_index];
					{r.out_residue, r.out_structure} = column_keys[c.entry_index];
				end else begin
					r.status = ST_BAD_INDEX;
				end
			end
		endcase
		r.distinct_keys = keys_held[DK_W-1:0];
		r.running_total = column_total;
		return r;
	endfunction

	// Add one command word to the backlog.
	task automatic push_word(logic [1:0] op, logic [15:0] key, logic [15:0] amt,
			logic [5:0] idx);
		queued_word_t q;
		q.word.opcode = op;
		{q.word.residue, q.word.structure_code} = key;
		q.word.amount = amt;
		q.word.entry_index = idx;
		q.drain = drain_next;
		drain_next = 1'b0;
		command_backlog.push_back(q);
	endtask

	// Random values at the width of the field they fill.
	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic logic [5:0] rand6();
		return 6'($urandom);
	endfunction

	// Amounts lean toward the edges, zero included.
	function automatic logic [15:0] draw_amount();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return 16'h0000;
		end else if (r < 3) begin
			return 16'h0001;
		end else if (r < 5) begin
			return COUNT_MAX;
		end
		return rand16();
	endfunction

	// Mixed traffic over a small pool of keys, so keys repeat often.
	task automatic mix_phase(int unsigned count);
		logic [15:0] pool [12];
		logic [15:0] k;
		int unsigned r;
		foreach (pool[i]) begin
			pool[i] = rand16();
		end
		pool[0] = 16'h0000;
		pool[11] = 16'hFFFF;
		drain_next = 1'b1;
		repeat (count) begin
			k = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 11)] : rand16();
			r = $urandom_range(0, 99);
			if (r < 3) begin
				push_word(OP_CLEAR, rand16(), rand16(), rand6());
			end else if (r < 55) begin
				push_word(OP_ADD, k, draw_amount(), rand6());
			end else if (r < 75) begin
				push_word(OP_LOOKUP, k, rand16(), rand6());
			end else begin
				push_word(OP_READ, rand16(), rand16(),
					($urandom_range(0, 3) == 0) ? rand6() : 6'($urandom_range(0, 15)));
			end
		end
	endtask

	// Clear, fill the table to the last slot, then press against the full table.
	task automatic fill_phase();
		bit taken [logic [15:0]];
		logic [15:0] filled[$];
		logic [15:0] k;
		drain_next = 1'b1;
		push_word(OP_CLEAR, rand16(), rand16(), rand6());
		while (filled.size() < TABLE_ENTRIES) begin
			k = (filled.size() < 4) ? CORNER_KEYS[filled.size()] : rand16();
			if (!taken.exists(k)) begin
				taken[k] = 1'b1;
				filled.push_back(k);
			end
			push_word(OP_ADD, k, draw_amount(), rand6());
			if ($urandom_range(0, 4) == 0) begin
				push_word(OP_READ, rand16(), rand16(), rand6());
			end
		end
		repeat (6) begin
			do begin
				k = rand16();
			end while (taken.exists(k));
			push_word(OP_ADD, k, draw_amount(), rand6());
			push_word(OP_ADD, filled[$urandom_range(0, TABLE_ENTRIES - 1)], draw_amount(),
				rand6());
			push_word(OP_READ, rand16(), rand16(), rand6());
			push_word(OP_LOOKUP, ($urandom_range(0, 1) == 0) ? k :
				filled[$urandom_range(0, TABLE_ENTRIES - 1)], rand16(), rand6());
		end
	endtask

	// Enough maximum adds to a few keys to cap their counts and the total.
	task automatic saturate_phase();
		logic [15:0] hot [3];
		foreach (hot[i]) begin
			hot[i] = rand16();
		end
		drain_next = 1'b1;
		repeat (300) begin
			push_word(OP_ADD, hot[$urandom_range(0, 2)], COUNT_MAX, rand6());
			if ($urandom_range(0, 14) == 0) begin
				push_word(OP_LOOKUP, hot[$urandom_range(0, 2)], rand16(), rand6());
			end
		end
	endtask

	task automatic compare_field(string name, logic [23:0] exp_val, logic [23:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Driver: a word is taken at an edge where start is high and busy is low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= '0;
		end else begin
			offer = start;
			next_word = command;
			if (start && !busy) begin
				expected_results.push_back(column_response(command));
				words_sent++;
				offer = 1'b0;
				if ($urandom_range(0, 39) == 0) begin
					steady = !steady;
				end
				gap_left = steady ? 0 : $urandom_range(0, 10);
			end
			if (!offer && command_backlog.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (!command_backlog[0].drain || words_seen == words_sent) begin
					head = command_backlog.pop_front();
					next_word = head.word;
					offer = 1'b1;
				end
			end
			start <= offer;
			command <= next_word;
		end
	end

	// Monitor: each result word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h", result);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				compare_field("status", 24'(want.status), 24'(result.status));
				compare_field("key_count", 24'(want.key_count), 24'(result.key_count));
				compare_field("out_residue", 24'(want.out_residue),
					24'(result.out_residue));
				compare_field("out_structure", 24'(want.out_structure),
					24'(result.out_structure));
				compare_field("distinct_keys", 24'(want.distinct_keys),
					24'(result.distinct_keys));
				compare_field("running_total", want.running_total, result.running_total);
			end
			words_seen <= words_seen + 1;
		end
	end

	initial begin
		wait (cycles_run >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;

		// Directed: empty table, ordering, zero amount, saturation, clear.
		drain_next = 1'b1;
		push_word(OP_CLEAR, 16'h0000, 16'h0000, 6'd0);
		push_word(OP_LOOKUP, 16'h1020, 16'h0000, 6'd0);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd0);
		push_word(OP_ADD, 16'h8007, 16'h0000, 6'd0);
		push_word(OP_ADD, 16'h0000, 16'h0001, 6'd0);
		push_word(OP_ADD, 16'hFFFF, 16'hFFFF, 6'd63);
		push_word(OP_ADD, 16'h8006, 16'h0003, 6'd0);
		push_word(OP_ADD, 16'h7FFF, 16'h0002, 6'd0);
		push_word(OP_ADD, 16'h8007, 16'hFFFF, 6'd0);
		push_word(OP_ADD, 16'h8007, 16'h0001, 6'd0);
		push_word(OP_LOOKUP, 16'h8007, 16'h0000, 6'd0);
		push_word(OP_LOOKUP, 16'h8008, 16'h0000, 6'd0);
		push_word(OP_READ, 16'hFFFF, 16'hFFFF, 6'd0);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd2);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd4);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd5);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd63);
		push_word(OP_ADD, 16'hFFFF, 16'hFFFF, 6'd0);
		push_word(OP_LOOKUP, 16'h0000, 16'h0000, 6'd0);
		push_word(OP_CLEAR, 16'hFFFF, 16'hFFFF, 6'd63);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd0);
		push_word(OP_LOOKUP, 16'h8007, 16'h0000, 6'd0);
		push_word(OP_ADD, 16'hAA55, 16'h5555, 6'd42);
		push_word(OP_READ, 16'h0000, 16'h0000, 6'd0);

		// Random part.
		mix_phase(60);
		fill_phase();
		mix_phase(60);
		saturate_phase();
		mix_phase(60);
		fill_phase();
		while (command_backlog.size() < WORD_TARGET) begin
			mix_phase(40);
		end
		total_words = command_backlog.size();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (words_sent == total_words && words_seen == total_words);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d words: %0d clears, %0d adds, %0d look-ups, %0d index reads.",
			total_words, op_tally[OP_CLEAR], op_tally[OP_ADD], op_tally[OP_LOOKUP],
			op_tally[OP_READ]);
		$display("Full-table refusals %0d, capped counts %0d, total capped %0d.",
			adds_refused, counts_capped, total_capped);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
